FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the upstream grant scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

`endif

FILE: src/ougs_pkg.sv
// Package: types, codes and constants of the upstream grant scheduler.
`default_nettype none
package ougs_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int TAG_W   = 16;
   localparam int LEN_W   = 14;
   localparam int ID_W    = 8;
   localparam int BYTES_W = 24;
   localparam int FLEN_W  = 10;
   localparam int DROP_W  = 32;
   localparam int ENTRY_W = TAG_W + LEN_W;

   localparam logic [1:0] KIND_ARRIVAL = 2'd0;
   localparam logic [1:0] KIND_GRANT   = 2'd1;
   localparam logic [1:0] KIND_PING    = 2'd2;

   localparam logic [1:0] OUT_DEPART = 2'd0;
   localparam logic [1:0] OUT_REPORT = 2'd1;
   localparam logic [1:0] OUT_PING   = 2'd2;

   localparam logic [1:0] CSR_BUFFER_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_ONU_ID          = 2'd1;
   localparam logic [1:0] CSR_REPORT_LENGTH   = 2'd2;

   localparam logic [BYTES_W-1:0] CAPACITY_RESET = 24'd10000000;
   localparam logic [ID_W-1:0]    ONU_ID_RESET   = 8'd0;
   localparam logic [FLEN_W-1:0]  REPORT_RESET   = 10'd64;

   typedef struct packed {
      logic [1:0]         kind;
      logic [TAG_W-1:0]   packet_tag;
      logic [LEN_W-1:0]   packet_length;
      logic [ID_W-1:0]    grant_target;
      logic [BYTES_W-1:0] grant_bytes;
   } item_type;

   typedef struct packed {
      logic [1:0]         out_kind;
      logic [TAG_W-1:0]   sent_tag;
      logic [LEN_W-1:0]   sent_length;
      logic [BYTES_W-1:0] request_bytes;
      logic [FLEN_W-1:0]  frame_length;
      logic [ID_W-1:0]    source_onu;
      logic [DROP_W-1:0]  dropped_total;
      logic               last;
   } result_type;

   typedef struct packed {
      logic [BYTES_W-1:0] buffer_capacity;
      logic [ID_W-1:0]    onu_id;
      logic [FLEN_W-1:0]  report_length;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0]   entry_count;
      logic [BYTES_W-1:0] pending_bytes;
      logic               busy;
   } status_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

endpackage
`default_nettype wire

FILE: src/ougs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ougs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/ougs_out.sv
// Result register between the scheduler and the result stream.
`default_nettype none
module ougs_out (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire ougs_pkg::result_type load_data,
   output logic                     slot_free,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output ougs_pkg::result_type     out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   ougs_pkg::result_type data_ff;

   assign slot_free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

FILE: src/ougs_sched.sv
// Queue control and grant sequencer around the packet store.
`default_nettype none
module ougs_sched (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ougs_pkg::cfg_type   cfg,
   input  wire logic                item_valid,
   output logic                     item_ready,
   input  wire ougs_pkg::item_type  item,
   input  wire logic                slot_free,
   output logic                     res_load,
   output ougs_pkg::result_type     res_data,
   output ougs_pkg::status_type     status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_PING
   } state_type;

   state_type                         state_ff, state_in;
   logic [ougs_pkg::PTR_W-1:0]        head_ff, head_in;
   logic [ougs_pkg::PTR_W-1:0]        tail_ff, tail_in;
   logic [ougs_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [ougs_pkg::BYTES_W-1:0]      pending_ff, pending_in;
   logic [ougs_pkg::BYTES_W-1:0]      credit_ff, credit_in;
   logic [ougs_pkg::DROP_W-1:0]       drop_ff, drop_in;

   logic                              accept;
   logic [ougs_pkg::BYTES_W:0]        future;
   logic                              admit;
   logic                              wr_en;
   logic [ougs_pkg::PTR_W-1:0]        rd_addr;
   logic [ougs_pkg::ENTRY_W-1:0]      entry;
   logic [ougs_pkg::LEN_W-1:0]        head_len;
   logic [ougs_pkg::BYTES_W-1:0]      head_len_ext;
   logic                              fits;
   logic                              depart;

   ougs_ram #(
      .WIDTH (ougs_pkg::ENTRY_W),
      .DEPTH (ougs_pkg::QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data ({item.packet_tag, item.packet_length}),
      .rd_addr (rd_addr),
      .rd_data (entry)
   );

   assign item_ready = (state_ff == S_IDLE);
   assign accept     = item_valid && item_ready;

   assign future = {1'b0, pending_ff} + (ougs_pkg::BYTES_W + 1)'(item.packet_length);
   assign admit  = (future <= {1'b0, cfg.buffer_capacity})
                   && (count_ff < ougs_pkg::CNT_W'(ougs_pkg::QUEUE_DEPTH));
   assign wr_en  = accept && (item.kind == ougs_pkg::KIND_ARRIVAL) && admit;

   assign head_len     = entry[ougs_pkg::LEN_W-1:0];
   assign head_len_ext = ougs_pkg::BYTES_W'(head_len);
   assign fits = (credit_ff != '0) && (pending_ff != '0) && (count_ff != '0)
                 && (head_len_ext <= credit_ff) && (head_len_ext <= pending_ff);
   assign depart  = (state_ff == S_EVAL) && fits && slot_free;
   assign rd_addr = depart ? ougs_pkg::ptr_inc(head_ff) : head_ff;

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      credit_in  = credit_ff;
      drop_in    = drop_ff;
      res_load   = 1'b0;
      res_data   = '0;
      res_data.dropped_total = drop_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (item.kind)
                  ougs_pkg::KIND_ARRIVAL: begin
                     if (admit) begin
                        tail_in    = ougs_pkg::ptr_inc(tail_ff);
                        count_in   = count_ff + ougs_pkg::CNT_W'(1);
                        pending_in = future[ougs_pkg::BYTES_W-1:0];
                     end else if (drop_ff != '1) begin
                        drop_in = drop_ff + ougs_pkg::DROP_W'(1);
                     end
                  end
                  ougs_pkg::KIND_GRANT: begin
                     if (item.grant_target == cfg.onu_id) begin
                        credit_in = item.grant_bytes;
                        state_in  = S_EVAL;
                     end
                  end
                  ougs_pkg::KIND_PING: begin
                     state_in = S_PING;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EVAL: begin
            if (slot_free) begin
               res_load = 1'b1;
               if (fits) begin
                  res_data.out_kind    = ougs_pkg::OUT_DEPART;
                  res_data.sent_tag    = entry[ougs_pkg::ENTRY_W-1:ougs_pkg::LEN_W];
                  res_data.sent_length = head_len;
                  head_in    = ougs_pkg::ptr_inc(head_ff);
                  count_in   = count_ff - ougs_pkg::CNT_W'(1);
                  credit_in  = credit_ff - head_len_ext;
                  pending_in = pending_ff - head_len_ext;
               end else begin
                  res_data.out_kind      = ougs_pkg::OUT_REPORT;
                  res_data.request_bytes = pending_ff;
                  res_data.frame_length  = cfg.report_length;
                  res_data.source_onu    = cfg.onu_id;
                  res_data.last          = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_PING: begin
            if (slot_free) begin
               res_load            = 1'b1;
               res_data.out_kind   = ougs_pkg::OUT_PING;
               res_data.source_onu = cfg.onu_id;
               res_data.last       = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         pending_ff <= '0;
         credit_ff  <= '0;
         drop_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
         credit_ff  <= credit_in;
         drop_ff    <= drop_in;
      end
   end

   assign status.entry_count   = count_ff;
   assign status.pending_bytes = pending_ff;
   assign status.busy          = (state_ff != S_IDLE);

endmodule
`default_nettype wire

FILE: src/onu_upstream_grant_scheduler.sv
// An arrival is queued at its transfer; a ping reply or the first result of a grant passes
// through the sequencer state register and then the result register. An arrival leaves the
// input ready; a ping or a grant for this ONU holds it low until the sequencer is idle again,
// which a held output delays. Departures run at one per cycle while the result register has
// a free slot, through the store's next-head address. Reset clears queue pointers, counters,
// credit and drop count and loads the register defaults; the packet store is not cleared.
`default_nettype none
`include "assert_macros.svh"
module onu_upstream_grant_scheduler (
   input  wire logic         clock,
   input  wire logic         reset,
   // req_tdata: packet_tag[15:0], packet_length[29:16], grant_target[37:30],
   // grant_bytes[61:38], zero[63:62]
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,
   // req_tuser: kind[1:0]
   input  wire logic [1:0]   req_tuser,
   // rsp_tdata: sent_tag[15:0], sent_length[29:16], request_bytes[53:30],
   // frame_length[63:54], source_onu[71:64], dropped_total[103:72]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata,
   // rsp_tuser: out_kind[1:0]
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [23:0]  csr_data
);

   ougs_pkg::cfg_type    cfg_ff, cfg_in;
   ougs_pkg::item_type   item;
   ougs_pkg::result_type res_data;
   ougs_pkg::result_type out_data;
   ougs_pkg::status_type status;
   logic                 slot_free;
   logic                 res_load;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ougs_pkg::CSR_BUFFER_CAPACITY: cfg_in.buffer_capacity = csr_data;
            ougs_pkg::CSR_ONU_ID:          cfg_in.onu_id = csr_data[ougs_pkg::ID_W-1:0];
            ougs_pkg::CSR_REPORT_LENGTH:   cfg_in.report_length =
                                              csr_data[ougs_pkg::FLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_capacity <= ougs_pkg::CAPACITY_RESET;
         cfg_ff.onu_id          <= ougs_pkg::ONU_ID_RESET;
         cfg_ff.report_length   <= ougs_pkg::REPORT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign item.kind          = req_tuser;
   assign item.packet_tag    = req_tdata[15:0];
   assign item.packet_length = req_tdata[29:16];
   assign item.grant_target  = req_tdata[37:30];
   assign item.grant_bytes   = req_tdata[61:38];

   ougs_sched u_sched (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .slot_free  (slot_free),
      .res_load   (res_load),
      .res_data   (res_data),
      .status     (status)
   );

   ougs_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (res_load),
      .load_data (res_data),
      .slot_free (slot_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tuser = out_data.out_kind;
   assign rsp_tlast = out_data.last;
   assign rsp_tdata = {out_data.dropped_total, out_data.source_onu, out_data.frame_length,
                       out_data.request_bytes, out_data.sent_length, out_data.sent_tag};

   `ASSERT_CLK(a_count_bound, clock, reset,
      (status.entry_count <= ougs_pkg::CNT_W'(ougs_pkg::QUEUE_DEPTH)),
      "queue entry count above depth")
   `ASSERT_IMPLY(a_empty_no_bytes, clock, reset, (status.entry_count == '0),
      (status.pending_bytes == '0), "pending bytes left in an empty queue")
   `ASSERT_IMPLY(a_last_kind, clock, reset, (rsp_tvalid && rsp_tlast),
      (rsp_tuser == ougs_pkg::OUT_REPORT || rsp_tuser == ougs_pkg::OUT_PING),
      "final result is not a report or ping reply")
   `ASSERT_IMPLY(a_depart_not_last, clock, reset, (rsp_tvalid && !rsp_tlast),
      (rsp_tuser == ougs_pkg::OUT_DEPART), "non-final result is not a departure")
   `ASSERT_IMPLY(a_busy_holds_input, clock, reset, status.busy, !req_tready,
      "input ready while the sequencer is busy")

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Stream testbench for the ONU upstream grant scheduler, checked against a queue-based predictor.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED  = 2'd3;
   localparam int HOLD_CYCLES = 600;
   localparam int TAIL_CYCLES = 10;

   typedef struct packed {
      logic [ougs_pkg::TAG_W-1:0] tag;
      logic [ougs_pkg::LEN_W-1:0] len;
   } queued_pkt_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [63:0]   req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          rsp_tlast;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index = '0;
   logic [23:0]   csr_data = '0;

   onu_upstream_grant_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // predictor state
   ougs_pkg::cfg_type regs = '{ougs_pkg::CAPACITY_RESET, ougs_pkg::ONU_ID_RESET,
                               ougs_pkg::REPORT_RESET};
   queued_pkt_type                onu_backlog[$];
   logic [ougs_pkg::BYTES_W-1:0]  pend_bytes = '0;
   logic [ougs_pkg::BYTES_W-1:0]  credit = '0;
   logic [ougs_pkg::DROP_W-1:0]   drops = '0;

   ougs_pkg::item_type   frames_to_send[$];
   ougs_pkg::result_type due_frames[$];
   ougs_pkg::item_type   offer;
   int         gap_pct = 0;
   int         stall_pct = 0;
   int         hold_seq = 0;
   int         hold_seen = 0;
   int         hold_left = 0;
   int         mismatches = 0;

   function automatic ougs_pkg::item_type mk(input logic [1:0] kind,
                                             input logic [ougs_pkg::TAG_W-1:0] tag,
                                             input logic [ougs_pkg::LEN_W-1:0] len,
                                             input logic [ougs_pkg::ID_W-1:0] target,
                                             input logic [ougs_pkg::BYTES_W-1:0] bytes);
      ougs_pkg::item_type it;
      it.kind          = kind;
      it.packet_tag    = tag;
      it.packet_length = len;
      it.grant_target  = target;
      it.grant_bytes   = bytes;
      return it;
   endfunction

   function automatic void schedule_frame(input ougs_pkg::item_type it);
      ougs_pkg::result_type         r;
      queued_pkt_type               head;
      logic [ougs_pkg::BYTES_W:0]   future;
      case (it.kind)
         ougs_pkg::KIND_ARRIVAL: begin
            future = {1'b0, pend_bytes} + it.packet_length;
            if (future <= regs.buffer_capacity &&
                onu_backlog.size() < ougs_pkg::QUEUE_DEPTH) begin
               onu_backlog.push_back('{it.packet_tag, it.packet_length});
               pend_bytes = future[ougs_pkg::BYTES_W-1:0];
            end else if (drops != '1) begin
               drops = drops + 1;
            end
         end
         ougs_pkg::KIND_GRANT: begin
            if (it.grant_target == regs.onu_id) begin
               credit = it.grant_bytes;
               while (credit != 0 && pend_bytes != 0 && onu_backlog.size() != 0) begin
                  head = onu_backlog[0];
                  if (head.len > credit || head.len > pend_bytes) break;
                  void'(onu_backlog.pop_front());
                  credit     = credit - head.len;
                  pend_bytes = pend_bytes - head.len;
                  r = '0;
                  r.out_kind      = ougs_pkg::OUT_DEPART;
                  r.sent_tag      = head.tag;
                  r.sent_length   = head.len;
                  r.dropped_total = drops;
                  due_frames.push_back(r);
               end
               r = '0;
               r.out_kind      = ougs_pkg::OUT_REPORT;
               r.request_bytes = pend_bytes;
               r.frame_length  = regs.report_length;
               r.source_onu    = regs.onu_id;
               r.dropped_total = drops;
               r.last          = 1'b1;
               due_frames.push_back(r);
            end
         end
         ougs_pkg::KIND_PING: begin
            r = '0;
            r.out_kind      = ougs_pkg::OUT_PING;
            r.source_onu    = regs.onu_id;
            r.dropped_total = drops;
            r.last          = 1'b1;
            due_frames.push_back(r);
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches < 60) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         end
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) schedule_frame(offer);
         if (frames_to_send.size() != 0 && $urandom_range(99) >= gap_pct) begin
            offer = frames_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {2'b00, offer.grant_bytes, offer.grant_target,
                           offer.packet_length, offer.packet_tag};
            req_tuser  <= offer.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      ougs_pkg::result_type got;
      ougs_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_kind      = rsp_tuser;
         got.sent_tag      = rsp_tdata[15:0];
         got.sent_length   = rsp_tdata[29:16];
         got.request_bytes = rsp_tdata[53:30];
         got.frame_length  = rsp_tdata[63:54];
         got.source_onu    = rsp_tdata[71:64];
         got.dropped_total = rsp_tdata[103:72];
         got.last          = rsp_tlast;
         if (due_frames.size() == 0) begin
            mismatches++;
            if (mismatches < 60) begin
               $display("%0t: transfer with nothing due, kind %0d tdata %h",
                        $time, got.out_kind, rsp_tdata);
            end
         end else begin
            want = due_frames.pop_front();
            compare_field("out_kind", want.out_kind, got.out_kind);
            compare_field("sent_tag", want.sent_tag, got.sent_tag);
            compare_field("sent_length", want.sent_length, got.sent_length);
            compare_field("request_bytes", want.request_bytes, got.request_bytes);
            compare_field("frame_length", want.frame_length, got.frame_length);
            compare_field("source_onu", want.source_onu, got.source_onu);
            compare_field("dropped_total", want.dropped_total, got.dropped_total);
            compare_field("last", want.last, got.last);
         end
      end
   end

   task automatic wait_quiet();
      do @(negedge clock);
      while (frames_to_send.size() != 0 || req_tvalid || due_frames.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ougs_pkg::CSR_BUFFER_CAPACITY: regs.buffer_capacity = val;
         ougs_pkg::CSR_ONU_ID:          regs.onu_id = val[ougs_pkg::ID_W-1:0];
         ougs_pkg::CSR_REPORT_LENGTH:   regs.report_length = val[ougs_pkg::FLEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_random(input int n);
      int made;
      int burst;
      int pick;
      logic [ougs_pkg::LEN_W-1:0]   len;
      logic [ougs_pkg::BYTES_W-1:0] bytes;
      ougs_pkg::item_type it;
      made = 0;
      while (made < n) begin
         if ($urandom_range(99) < 75) begin
            burst = $urandom_range(1, 10);
            repeat (burst) begin
               pick = $urandom_range(99);
               if (pick < 5) len = '0;
               else if (pick < 15) len = ougs_pkg::LEN_W'($urandom_range(8192, 16383));
               else len = ougs_pkg::LEN_W'($urandom_range(1, 1500));
               frames_to_send.push_back(mk(ougs_pkg::KIND_ARRIVAL,
                                           ougs_pkg::TAG_W'($urandom()), len,
                                           ougs_pkg::ID_W'($urandom()),
                                           ougs_pkg::BYTES_W'($urandom())));
            end
            pick = $urandom_range(99);
            if (pick < 30) bytes = ougs_pkg::BYTES_W'($urandom());
            else if (pick < 50) bytes = '1;
            else if (pick < 58) bytes = '0;
            else bytes = ougs_pkg::BYTES_W'($urandom_range(1, 6000));
            frames_to_send.push_back(mk(ougs_pkg::KIND_GRANT, ougs_pkg::TAG_W'($urandom()),
                                        ougs_pkg::LEN_W'($urandom()), regs.onu_id, bytes));
            made += burst + 1;
            if ($urandom_range(99) < 30) begin
               frames_to_send.push_back(mk(ougs_pkg::KIND_PING,
                                           ougs_pkg::TAG_W'($urandom()),
                                           ougs_pkg::LEN_W'($urandom()),
                                           ougs_pkg::ID_W'($urandom()),
                                           ougs_pkg::BYTES_W'($urandom())));
               made++;
            end
         end else begin
            it = mk(2'($urandom_range(0, 3)), ougs_pkg::TAG_W'($urandom()),
                    ougs_pkg::LEN_W'($urandom()), ougs_pkg::ID_W'($urandom()),
                    ougs_pkg::BYTES_W'($urandom()));
            frames_to_send.push_back(it);
            if (it.kind == ougs_pkg::KIND_ARRIVAL || it.kind == ougs_pkg::KIND_PING ||
                (it.kind == ougs_pkg::KIND_GRANT && it.grant_target == regs.onu_id)) begin
               made++;
            end
         end
      end
   endtask

   task automatic run_phase(input logic [23:0] cap, input logic [23:0] id,
                            input logic [23:0] rlen, input int gap, input int stall,
                            input int n);
      wait_quiet();
      gap_pct   = gap;
      stall_pct = stall;
      write_reg(ougs_pkg::CSR_BUFFER_CAPACITY, cap);
      write_reg(ougs_pkg::CSR_ONU_ID, id);
      write_reg(ougs_pkg::CSR_REPORT_LENGTH, rlen);
      queue_random(n);
   endtask

   initial begin
      #1_000_000;
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      int i;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset configuration, no idling
      frames_to_send.push_back(mk(ougs_pkg::KIND_PING, 16'hFFFF, 14'h3FFF, 8'hFF,
                                  24'hFFFFFF));
      frames_to_send.push_back(mk(ougs_pkg::KIND_GRANT, '0, '0, 8'd0, 24'd100));
      frames_to_send.push_back(mk(ougs_pkg::KIND_ARRIVAL, 16'h0000, 14'd1, '0, '0));
      frames_to_send.push_back(mk(ougs_pkg::KIND_ARRIVAL, 16'hFFFF, 14'd16383, '1, '1));
      frames_to_send.push_back(mk(ougs_pkg::KIND_ARRIVAL, 16'h1234, 14'd0, '0, '0));
      frames_to_send.push_back(mk(ougs_pkg::KIND_ARRIVAL, 16'h5A5A, 14'd7, '0, '0));
      frames_to_send.push_back(mk(ougs_pkg::KIND_GRANT, '0, '0, 8'd0, 24'd0));
      frames_to_send.push_back(mk(ougs_pkg::KIND_GRANT, '0, '0, 8'd0, 24'd1));
      frames_to_send.push_back(mk(ougs_pkg::KIND_GRANT, '0, '0, 8'hFF, 24'hFFFFFF));
      frames_to_send.push_back(mk(KIND_UNUSED, 16'hFFFF, 14'h3FFF, 8'd0, 24'hFFFFFF));
      frames_to_send.push_back(mk(ougs_pkg::KIND_GRANT, '0, '0, 8'd0, 24'hFFFFFF));
      frames_to_send.push_back(mk(ougs_pkg::KIND_ARRIVAL, 16'h0404, 14'd4, '0, '0));
      frames_to_send.push_back(mk(ougs_pkg::KIND_ARRIVAL, 16'h0000, 14'd0, '0, '0));
      frames_to_send.push_back(mk(ougs_pkg::KIND_GRANT, '0, '0, 8'd0, 24'hFFFFFF));
      frames_to_send.push_back(mk(ougs_pkg::KIND_ARRIVAL, 16'h0909, 14'd9, '0, '0));
      frames_to_send.push_back(mk(ougs_pkg::KIND_GRANT, '0, '0, 8'd0, 24'd9));
      frames_to_send.push_back(mk(ougs_pkg::KIND_PING, '0, '0, '0, '0));

      run_phase(24'hFFFFFF, 24'h0000FF, 24'h0003FF, 55, 0, 35);

      // hold the output long enough that the queue and the output path back up
      wait_quiet();
      gap_pct   = 0;
      stall_pct = 0;
      write_reg(ougs_pkg::CSR_ONU_ID, 24'h000003);
      write_reg(ougs_pkg::CSR_REPORT_LENGTH, 24'hFFF155);
      write_reg(CSR_UNUSED, 24'hFFFFFF);
      hold_seq++;
      for (i = 0; i < 36; i++) begin
         frames_to_send.push_back(mk(ougs_pkg::KIND_ARRIVAL, ougs_pkg::TAG_W'($urandom()),
                                     ougs_pkg::LEN_W'($urandom_range(1, 400)), '0, '0));
      end
      frames_to_send.push_back(mk(ougs_pkg::KIND_GRANT, '0, '0, 8'd3, 24'hFFFFFF));
      repeat (3) frames_to_send.push_back(mk(ougs_pkg::KIND_PING, '0, '0, '0, '0));
      frames_to_send.push_back(mk(ougs_pkg::KIND_GRANT, '0, '0, 8'd3, 24'hFFFFFF));

      run_phase(24'h000000, 24'h000000, 24'h000000, 0, 55, 35);
      run_phase(24'd20000, 24'($urandom()), 24'($urandom()), 15, 15, 35);
      run_phase(24'($urandom()), 24'($urandom()), 24'($urandom()), 0, 0, 35);
      run_phase(24'd60000, 24'h00005A, 24'h000001, 55, 0, 35);
      run_phase(24'd300000, 24'($urandom()), 24'($urandom()), 0, 55, 35);
      wait_quiet();

      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
